>>> sv/hcfs_pkg.sv
// ----------------------------------------------------------------------------
// hcfs_pkg: shared types and constants for the hashed channel select block
// Field widths, configuration register indexes, reset values, the djb2 seed,
// the divider step counts and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package hcfs_pkg;

  // Payload field widths.
  localparam int BYTE_W  = 8;
  localparam int HASH_W  = 32;
  localparam int COUNT_W = 16;
  localparam int FREQ_W  = 31;

  // Configuration register widths.
  localparam int EDGE_W  = 30;
  localparam int BW_W    = 20;
  localparam int CFG_W   = 30;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [EDGE_W-1:0] FREQ_START_RST = 30'd869400000;
  localparam logic [EDGE_W-1:0] FREQ_END_RST   = 30'd869650000;
  localparam logic [BW_W-1:0]   BANDWIDTH_RST  = 20'd250000;

  // djb2 seed and the saturated channel count.
  localparam logic [HASH_W-1:0]  HASH_SEED = 32'd5381;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Step counter of the shared divider.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] CNT_STEPS_M1 = 5'd15;
  localparam logic [STEP_W-1:0] MOD_STEPS_M1 = 5'd31;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CNT  = 5'b00010,
    S_MOD  = 5'b00100,
    S_MUL  = 5'b01000,
    S_SUM  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

>>> sv/hcfs_if.sv
// ----------------------------------------------------------------------------
// hcfs_if: valid/ready channels of the hashed channel select block
// One channel carries name bytes in, the other carries the selected channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Name byte channel.
interface hcfs_name_if import hcfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] name_byte;
  logic              last_byte;

  modport source (output valid, output name_byte, output last_byte, input ready);
  modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

// Result channel.
interface hcfs_result_if import hcfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HASH_W-1:0]  name_hash;
  logic [COUNT_W-1:0] channel_count;
  logic [COUNT_W-1:0] channel_slot;
  logic [FREQ_W-1:0]  center_freq_hz;

  modport source (output valid, output name_hash, output channel_count,
                  output channel_slot, output center_freq_hz, input ready);
  modport sink   (input valid, input name_hash, input channel_count,
                  input channel_slot, input center_freq_hz, output ready);
endinterface

`default_nettype wire

>>> sv/hashed_channel_frequency_select.sv
// ----------------------------------------------------------------------------
// hashed_channel_frequency_select: channel choice from a hashed name
// Hashes a channel name with djb2 and maps it onto a channel of the band.
//
// Usage:
//   name_ch carries one name byte per item; last_byte marks the end of a name.
//   Each byte is folded into the running hash in the cycle it is accepted, so
//   bytes inside a name go at one item per cycle.
//   On the last byte the block drops ready and runs a shift-subtract divider:
//   16 steps for the channel count (skipped when the band is empty or the
//   count saturates), then 32 steps for the hash modulo the count (skipped
//   when the count is zero), then a multiply state and a sum state, which
//   registers the result on result_ch.
//   result_ch is held in an output register; a new name may start while a
//   result waits, and only the final sum cycle stalls until that register
//   is free.
//   The user sets the band through cfg_we, cfg_index and cfg_data only while idle;
//   the block does not enforce this. Reset (synchronous, active high) restores the
//   default band, returns the hash to its seed and clears any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_channel_frequency_select import hcfs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  hcfs_name_if.sink                 name_ch,
  hcfs_result_if.source             result_ch
);

  // Configuration registers.
  logic [EDGE_W-1:0] freq_start_hz;
  logic [EDGE_W-1:0] freq_end_hz;
  logic [BW_W-1:0]   bandwidth_hz;

  // Sequencer and working registers.
  state_t             state;
  logic [HASH_W-1:0]  running_hash;
  logic [HASH_W-1:0]  hash_hold;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] slot;
  logic [BW_W-1:0]    rem;
  logic [BW_W-1:0]    divisor;
  logic [HASH_W-1:0]  dvd;
  logic [STEP_W-1:0]  step;
  logic [FREQ_W-1:0]  prod;

  // Output register.
  logic               out_valid;
  logic [HASH_W-1:0]  out_hash;
  logic [COUNT_W-1:0] out_count;
  logic [COUNT_W-1:0] out_slot;
  logic [FREQ_W-1:0]  out_freq;

  logic               in_take;
  logic               out_free;
  logic [HASH_W-1:0]  hash_next;
  logic [EDGE_W-1:0]  span;
  logic               band_empty;
  logic               count_sat;
  logic [BW_W:0]      trial;
  logic [BW_W:0]      diff;
  logic               ge;
  logic [BW_W-1:0]    rem_next;
  logic [HASH_W-1:0]  dvd_next;

  assign name_ch.ready = (state == S_IDLE);
  assign in_take       = name_ch.valid && name_ch.ready;
  assign out_free      = !out_valid || result_ch.ready;

  // djb2 step: h * 33 + byte, wrapping at 32 bits.
  assign hash_next = (running_hash << 5) + running_hash
                   + {{(HASH_W-BYTE_W){1'b0}}, name_ch.name_byte};

  // Band checks for the channel count.
  assign span       = freq_end_hz - freq_start_hz;
  assign band_empty = (bandwidth_hz == '0) || (freq_end_hz <= freq_start_hz);
  assign count_sat  = {{(BW_W+COUNT_W-EDGE_W){1'b0}}, span}
                      >= {bandwidth_hz, {COUNT_W{1'b0}}};

  // Shared restoring divider step: one quotient bit per cycle.
  assign trial    = {rem, dvd[HASH_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_next = ge ? diff[BW_W-1:0] : trial[BW_W-1:0];
  assign dvd_next = {dvd[HASH_W-2:0], ge};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_start_hz <= FREQ_START_RST;
      freq_end_hz   <= FREQ_END_RST;
      bandwidth_hz  <= BANDWIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FREQ_START: freq_start_hz <= cfg_data[EDGE_W-1:0];
        CFG_FREQ_END:   freq_end_hz   <= cfg_data[EDGE_W-1:0];
        CFG_BANDWIDTH:  bandwidth_hz  <= cfg_data[BW_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state: sequencer, running hash and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_hash <= HASH_SEED;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_SUM && out_free) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (name_ch.last_byte) begin
              running_hash <= HASH_SEED;
              if (band_empty) begin
                state <= S_MUL;
              end else if (count_sat) begin
                state <= S_MOD;
              end else begin
                state <= S_CNT;
              end
            end else begin
              running_hash <= hash_next;
            end
          end
        end
        S_CNT: begin
          if (step == '0) begin
            state <= (dvd_next[COUNT_W-1:0] == '0) ? S_MUL : S_MOD;
          end
        end
        S_MOD: begin
          if (step == '0) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the divider, multiplier and result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take && name_ch.last_byte) begin
          hash_hold <= hash_next;
          if (band_empty) begin
            count <= '0;
            slot  <= '0;
          end else if (count_sat) begin
            count   <= COUNT_MAX;
            dvd     <= hash_next;
            rem     <= '0;
            divisor <= {{(BW_W-COUNT_W){1'b0}}, COUNT_MAX};
            step    <= MOD_STEPS_M1;
          end else begin
            // Quotient fits 16 bits, so the top of the span seeds the remainder.
            dvd     <= {span[COUNT_W-1:0], {(HASH_W-COUNT_W){1'b0}}};
            rem     <= {{(BW_W+COUNT_W-EDGE_W){1'b0}}, span[EDGE_W-1:COUNT_W]};
            divisor <= bandwidth_hz;
            step    <= CNT_STEPS_M1;
          end
        end
      end
      S_CNT: begin
        if (step == '0) begin
          count <= dvd_next[COUNT_W-1:0];
          slot  <= '0;
          dvd     <= hash_hold;
          rem     <= '0;
          divisor <= {{(BW_W-COUNT_W){1'b0}}, dvd_next[COUNT_W-1:0]};
          step    <= MOD_STEPS_M1;
        end else begin
          dvd  <= dvd_next;
          rem  <= rem_next;
          step <= step - 1'b1;
        end
      end
      S_MOD: begin
        dvd  <= dvd_next;
        rem  <= rem_next;
        step <= step - 1'b1;
        if (step == '0) begin
          slot <= rem_next[COUNT_W-1:0];
        end
      end
      S_MUL: begin
        prod <= FREQ_W'(slot * bandwidth_hz);
      end
      S_SUM: begin
        if (out_free) begin
          out_hash  <= hash_hold;
          out_count <= count;
          out_slot  <= slot;
          out_freq  <= FREQ_W'(freq_start_hz) + FREQ_W'(bandwidth_hz >> 1) + prod;
        end
      end
      default: ;
    endcase
  end

  assign result_ch.valid          = out_valid;
  assign result_ch.name_hash      = out_hash;
  assign result_ch.channel_count  = out_count;
  assign result_ch.channel_slot   = out_slot;
  assign result_ch.center_freq_hz = out_freq;

  // The partial remainder always stays below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_CNT || state == S_MOD) |-> rem < divisor)
    else $error("divider remainder reached the divisor");

  // A chosen slot lies inside the band.
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_count != '0) |-> out_slot < out_count)
    else $error("channel slot outside the channel count");

  // A zero channel count always selects slot zero.
  a_empty_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_count == '0) |-> out_slot == '0)
    else $error("non-zero slot with zero channels");

  // The hash restarts from its seed after the end of a name.
  a_hash_reseed: assert property (@(posedge clk) disable iff (rst)
    (in_take && name_ch.last_byte) |=> running_hash == HASH_SEED)
    else $error("running hash not reseeded after last byte");

  // A finished result waits in the sum cycle until the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && out_valid && !result_ch.ready) |=> state == S_SUM)
    else $error("result left the sum cycle over a pending result");

endmodule

`default_nettype wire
